>>> rtl/core/bbl_pkg.sv
`default_nettype none
package bbl_pkg;

  localparam int CapacityDefault = 16;
  localparam int KeyW = 32;
  localparam int StampW = 64;
  localparam int SizeW = 32;
  localparam int TotW = 36;
  localparam int DropW = 5;
  localparam int AddrW = 4;
  localparam int DataW = 64;

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpTouch  = 3'd1;
  localparam logic [2:0] OpRemove = 3'd2;
  localparam logic [2:0] OpLookup = 3'd3;
  localparam logic [2:0] OpTrim   = 3'd4;
  localparam logic [2:0] OpClear  = 3'd5;

  localparam logic KindStatus = 1'b0;
  localparam logic KindNotice = 1'b1;

  localparam logic [AddrW-1:0] RegBudget = 4'd0;

  typedef struct packed {
    logic [2:0]               op;
    logic [KeyW-1:0]          key;
    logic signed [StampW-1:0] stamp;
    logic [SizeW-1:0]         size_bytes;
    logic [TotW-1:0]          target_bytes;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [KeyW-1:0]  out_key;
    logic             hit;
    logic             fresh;
    logic [DropW-1:0] dropped;
    logic [TotW-1:0]  total_out;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic find;
    logic evict;
    logic place;
    logic drop_keep;
    logic touch;
    logic remove;
    logic clear;
    logic status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       hit;
    logic       full;
    logic       over;
    logic       oldest_keep;
    logic       budget_nz;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/bbl_req_if.sv
`default_nettype none
interface bbl_req_if import bbl_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [2:0]               op;
  logic [KeyW-1:0]          key;
  logic signed [StampW-1:0] stamp;
  logic [SizeW-1:0]         size_bytes;
  logic [TotW-1:0]          target_bytes;

  modport source (output valid, op, key, stamp, size_bytes, target_bytes, input ready);
  modport sink (input valid, op, key, stamp, size_bytes, target_bytes, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bbl_rsp_if.sv
`default_nettype none
interface bbl_rsp_if import bbl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KeyW-1:0]  out_key;
  logic             hit;
  logic             fresh;
  logic [DropW-1:0] dropped;
  logic [TotW-1:0]  total_out;
  logic             last;

  modport source (output valid, kind, out_key, hit, fresh, dropped, total_out, last,
                  input ready);
  modport sink (input valid, kind, out_key, hit, fresh, dropped, total_out, last,
                output ready);
endinterface
`default_nettype wire

>>> rtl/core/bbl_ctrl.sv
`default_nettype none
module bbl_ctrl import bbl_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SFind   = 3'd1;
  localparam logic [2:0] SExec   = 3'd2;
  localparam logic [2:0] SFull   = 3'd3;
  localparam logic [2:0] SPlace  = 3'd4;
  localparam logic [2:0] STrim   = 3'd5;
  localparam logic [2:0] SStatus = 3'd6;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      SIdle: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = SFind;
        end
      end
      SFind: begin
        cmd.find   = 1'b1;
        state_next = SExec;
      end
      SExec: begin
        case (sts.op)
          OpInsert: state_next = (!sts.hit && sts.full) ? SFull : SPlace;
          OpTouch: begin
            cmd.touch  = 1'b1;
            state_next = SStatus;
          end
          OpRemove: begin
            cmd.remove = 1'b1;
            state_next = SStatus;
          end
          OpTrim: state_next = STrim;
          OpClear: begin
            cmd.clear  = 1'b1;
            state_next = SStatus;
          end
          default: state_next = SStatus;
        endcase
      end
      SFull: begin
        if (!sts.out_busy) begin
          cmd.evict  = 1'b1;
          state_next = SPlace;
        end
      end
      SPlace: begin
        cmd.place  = 1'b1;
        state_next = sts.budget_nz ? STrim : SStatus;
      end
      STrim: begin
        if (!sts.over) begin
          state_next = SStatus;
        end else if (sts.op == OpInsert && sts.oldest_keep) begin
          cmd.drop_keep = 1'b1;
          state_next    = SStatus;
        end else if (!sts.out_busy) begin
          cmd.evict = 1'b1;
        end
      end
      SStatus: begin
        if (!sts.out_busy) begin
          cmd.status = 1'b1;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/bbl_datapath.sv
`default_nettype none
module bbl_datapath import bbl_pkg::*; #(
  parameter int CAPACITY = CapacityDefault
) (
  input  wire             clk,
  input  wire             rst,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  req_t            req_data,
  input  wire [TotW-1:0]  budget,
  output rsp_t            rsp_data,
  output logic            out_valid,
  input  wire             out_ready
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = TotW + CW;

  logic [CAPACITY-1:0]      used;
  logic [KeyW-1:0]          key_q   [CAPACITY];
  logic [StampW-1:0]        stamp_q [CAPACITY];
  logic [SizeW-1:0]         size_q  [CAPACITY];
  logic [IW-1:0]            age     [CAPACITY];
  logic [TW-1:0]            total;
  logic [CW-1:0]            count;
  logic [CW-1:0]            cnt;
  req_t                     cur;
  logic                     hit_r;
  logic [IW-1:0]            idx_r;

  logic                     hit_any;
  logic [IW-1:0]            hit_idx, free_idx, oldest_idx, drop_idx;
  logic                     do_drop, do_newest;
  logic [TW-1:0]            total_drop;
  logic [TotW-1:0]          lim;

  always_comb begin
    hit_any    = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    oldest_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (used[i] && key_q[i] == cur.key) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!used[i]) free_idx = IW'(i);
      if (used[i] && age[i] == IW'(count - CW'(1))) oldest_idx = IW'(i);
    end
  end

  assign drop_idx   = cmd.evict ? oldest_idx : idx_r;
  assign do_drop    = cmd.evict || cmd.drop_keep || (cmd.remove && hit_r);
  assign do_newest  = (cmd.touch || cmd.place) && hit_r;
  assign total_drop = total - TW'(size_q[drop_idx]);
  assign lim        = (cur.op == OpInsert) ? budget : cur.target_bytes;

  function automatic logic [TotW-1:0] sat(input logic [TW-1:0] v);
    return (|v[TW-1:TotW]) ? {TotW{1'b1}} : v[TotW-1:0];
  endfunction

  assign sts.op          = cur.op;
  assign sts.hit         = hit_r;
  assign sts.full        = (count == CW'(CAPACITY));
  assign sts.over        = (total > TW'(lim));
  assign sts.oldest_keep = (oldest_idx == idx_r);
  assign sts.budget_nz   = (budget != '0);
  assign sts.out_busy    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= req_data;
    if (cmd.find) idx_r <= hit_idx;
    if (cmd.place) begin
      if (hit_r) begin
        stamp_q[idx_r] <= cur.stamp;
        size_q[idx_r]  <= cur.size_bytes;
      end else begin
        key_q[free_idx]   <= cur.key;
        stamp_q[free_idx] <= cur.stamp;
        size_q[free_idx]  <= cur.size_bytes;
        idx_r             <= free_idx;
      end
    end
    if (cmd.evict) begin
      rsp_data.kind      <= KindNotice;
      rsp_data.out_key   <= key_q[oldest_idx];
      rsp_data.hit       <= 1'b0;
      rsp_data.fresh     <= 1'b0;
      rsp_data.dropped   <= DropW'(cnt + CW'(1));
      rsp_data.total_out <= sat(total_drop);
      rsp_data.last      <= 1'b0;
    end
    if (cmd.status) begin
      rsp_data.kind      <= KindStatus;
      rsp_data.out_key   <= cur.key;
      rsp_data.hit       <= hit_r && (cur.op <= OpLookup);
      rsp_data.fresh     <= hit_r && (cur.op == OpLookup) && (stamp_q[idx_r] == cur.stamp);
      rsp_data.dropped   <= DropW'(cnt);
      rsp_data.total_out <= sat(total);
      rsp_data.last      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      total     <= '0;
      count     <= '0;
      cnt       <= '0;
      hit_r     <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) age[i] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.capture) cnt <= '0;
      if (cmd.find) hit_r <= hit_any;
      if (do_drop) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (used[i] && age[i] > age[drop_idx]) age[i] <= age[i] - IW'(1);
        end
        used[drop_idx] <= 1'b0;
        age[drop_idx]  <= '0;
        total          <= total_drop;
        count          <= count - CW'(1);
      end
      if (cmd.evict) begin
        cnt       <= cnt + CW'(1);
        out_valid <= 1'b1;
      end
      if (do_newest) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (used[i] && IW'(i) != idx_r && age[i] < age[idx_r]) age[i] <= age[i] + IW'(1);
        end
        age[idx_r] <= '0;
      end
      if (cmd.place) begin
        if (hit_r) begin
          total <= total - TW'(size_q[idx_r]) + TW'(cur.size_bytes);
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (used[i]) age[i] <= age[i] + IW'(1);
          end
          used[free_idx] <= 1'b1;
          age[free_idx]  <= '0;
          total          <= total + TW'(cur.size_bytes);
          count          <= count + CW'(1);
        end
      end
      if (cmd.clear) begin
        used  <= '0;
        total <= '0;
        count <= '0;
        for (int i = 0; i < CAPACITY; i++) age[i] <= '0;
      end
      if (cmd.status) out_valid <= 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/byte_budget_lru_cache.sv
// Byte-budget LRU table, fully associative over CAPACITY entries.
// req channel: one transaction per operation (insert/update, touch, remove,
//   lookup, trim, clear); ready is high only while the controller is idle.
// rsp channel: zero or more eviction notices (kind 1) followed by one status
//   (kind 0, last 1) per operation.
// APB port: budget_bytes at address 0, 64-bit data, no wait states.
// Sequence: the key match runs in the cycle after acceptance, then the operation
//   runs and the status transaction follows; trim, and an insert under a
//   nonzero budget, pass through the trim step before the status.
// Evictions are walked one entry at a time, oldest first; a new operation is
//   accepted only after the previous status transaction has been issued.
// Reset: all entries invalid, ages and byte total zero, budget zero. Key,
//   stamp and size storage are not cleared.
// A stalled receiver holds the single output register; the walk pauses on
//   the next notice or status until the transaction completes.
`default_nettype none
module byte_budget_lru_cache import bbl_pkg::*; #(
  parameter int CAPACITY = CapacityDefault
) (
  input  wire              clk,
  input  wire              rst,
  bbl_req_if.sink          req,
  bbl_rsp_if.source        rsp,
  input  wire              psel,
  input  wire              penable,
  input  wire              pwrite,
  input  wire [AddrW-1:0]  paddr,
  input  wire [DataW-1:0]  pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cmd_t            cmd;
  sts_t            sts;
  req_t            req_data;
  rsp_t            rsp_data;
  logic [TotW-1:0] budget;

  assign pready = 1'b1;
  assign prdata = (paddr == RegBudget) ? DataW'(budget) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
    end else if (psel && penable && pwrite && paddr == RegBudget) begin
      budget <= pwdata[TotW-1:0];
    end
  end

  assign req_data.op           = req.op;
  assign req_data.key          = req.key;
  assign req_data.stamp        = req.stamp;
  assign req_data.size_bytes   = req.size_bytes;
  assign req_data.target_bytes = req.target_bytes;

  assign rsp.kind      = rsp_data.kind;
  assign rsp.out_key   = rsp_data.out_key;
  assign rsp.hit       = rsp_data.hit;
  assign rsp.fresh     = rsp_data.fresh;
  assign rsp.dropped   = rsp_data.dropped;
  assign rsp.total_out = rsp_data.total_out;
  assign rsp.last      = rsp_data.last;

  bbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbl_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req_data),
    .budget    (budget),
    .rsp_data  (rsp_data),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready)
  );

endmodule
`default_nettype wire

>>> rtl/core/bbl_checker.sv
`default_nettype none
module bbl_checker (
  input wire clk,
  input wire rst,
  input wire rsp_valid,
  input wire rsp_ready,
  input wire rsp_kind,
  input wire rsp_hit,
  input wire rsp_fresh,
  input wire rsp_last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp valid dropped while stalled");

  a_notice: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind |-> !rsp_last && !rsp_hit && !rsp_fresh)
    else $error("eviction notice carries status flags");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_kind |-> rsp_last)
    else $error("status transaction without last");

  a_fresh_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_fresh |-> rsp_hit)
    else $error("fresh without hit");

endmodule

bind byte_budget_lru_cache bbl_checker u_bbl_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_kind  (rsp.kind),
  .rsp_hit   (rsp.hit),
  .rsp_fresh (rsp.fresh),
  .rsp_last  (rsp.last)
);
`default_nettype wire
